FILE: design/btlv_pkg.sv
// Package with types, codes and constants shared by the BER-TLV stream parser.
package btlv_pkg;

  localparam int unsigned DefMaxTagBytes = 4;
  localparam int unsigned DefMaxLenBytes = 8;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHECK_TAG          = 2'd0,
    CFG_EXPECTED_TAG       = 2'd1,
    CFG_EXPECTED_TAG_BYTES = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_TAG_FIRST = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_VALUE     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic {
    ERR_TAG_MISMATCH = 1'b0,
    ERR_LEN_BYTES    = 1'b1
  } err_e;

  localparam logic [4:0] TagMultiMark = 5'h1f;

endpackage

FILE: design/ber_tlv_stream_parser_top.sv
// BER-TLV stream parser: byte input register, tag/length/value decode, result register.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------------------
//   input     | in_valid_i / in_ready_o    | data_byte_i
//   result    | out_valid_o / out_ready_i  | kind_o, tag_value_o, tag_bytes_o,
//             |                            | element_length_o, value_byte_o, last_o,
//             |                            | error_code_o
//   config    | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// One byte per cycle is sustained while the result register is not stalled.
// The input register decodes against the parser state as soon as the result register is free.
// A stalled result register holds the byte in the input register, and no further byte is taken.
// Reset returns the parser to the first tag byte; payload registers are not reset.
module ber_tlv_stream_parser_top
  import btlv_pkg::*;
#(
  parameter int unsigned MaxTagBytes = DefMaxTagBytes,
  parameter int unsigned MaxLenBytes = DefMaxLenBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [31:0]         tag_value_o,
  output logic [2:0]          tag_bytes_o,
  output logic [63:0]         element_length_o,
  output logic [7:0]          value_byte_o,
  output logic                last_o,
  output logic                error_code_o
);

  localparam int unsigned TagCntW = $clog2(MaxTagBytes + 1);
  localparam int unsigned LenCntW = $clog2(MaxLenBytes + 1);
  localparam int unsigned CmpW    = (TagCntW > 3) ? TagCntW : 3;

  logic               check_tag_q;
  logic [31:0]        exp_tag_q;
  logic [2:0]         exp_bytes_q;

  logic               s1_valid_q, s1_valid_d;
  logic [7:0]         s1_data_q;

  phase_e             phase_q, phase_d;
  logic [31:0]        tag_acc_q, tag_acc_d;
  logic [TagCntW-1:0] tag_cnt_q, tag_cnt_d;
  logic [63:0]        len_acc_q, len_acc_d;
  logic [LenCntW-1:0] len_left_q, len_left_d;
  logic [63:0]        val_left_q, val_left_d;

  logic               res_valid_d;
  kind_e              res_kind_d;
  logic               res_last_d;
  err_e               res_err_d;

  logic               out_free, s1_fire;
  logic [7:0]         b;
  logic               tag_phase, tag_first;
  logic [31:0]        tag_acc_nx;
  logic [TagCntW-1:0] tag_cnt_nx;
  logic               tag_cont, tag_fin, tag_bad;
  logic               len_err, hdr_fire;
  logic [63:0]        len_nx;
  logic               val_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_tag_q <= 1'b0;
      exp_tag_q   <= '0;
      exp_bytes_q <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CHECK_TAG:          check_tag_q <= cfg_wdata_i[0];
        CFG_EXPECTED_TAG:       exp_tag_q   <= cfg_wdata_i[31:0];
        CFG_EXPECTED_TAG_BYTES: exp_bytes_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign s1_valid_d = (in_valid_i && in_ready_o) || (s1_valid_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= data_byte_i;
    end
  end

  assign b          = s1_data_q;
  assign tag_first  = (phase_q == PH_TAG_FIRST);
  assign tag_phase  = tag_first || (phase_q == PH_TAG_MORE);
  assign tag_acc_nx = tag_first ? {24'd0, b} : {tag_acc_q[23:0], b};
  assign tag_cnt_nx = tag_first ? TagCntW'(1) : tag_cnt_q + TagCntW'(1);
  assign tag_cont   = (tag_first ? (b[4:0] == TagMultiMark) : b[7])
                      && (tag_cnt_nx < TagCntW'(MaxTagBytes));
  assign tag_fin    = tag_phase && !tag_cont;
  assign tag_bad    = check_tag_q && ((CmpW'(tag_cnt_nx) != CmpW'(exp_bytes_q))
                      || (tag_acc_nx != exp_tag_q));

  assign len_err  = (phase_q == PH_LEN_FIRST) && b[7] && (b[6:0] > 7'(MaxLenBytes));
  assign hdr_fire = ((phase_q == PH_LEN_FIRST) && (!b[7] || (b[6:0] == 7'd0)))
                    || ((phase_q == PH_LEN_MORE) && (len_left_q == LenCntW'(1)));
  always_comb begin
    if (phase_q == PH_LEN_FIRST) begin
      len_nx = b[7] ? 64'd0 : {56'd0, b};
    end else begin
      len_nx = {len_acc_q[55:0], b};
    end
  end
  assign val_last = (val_left_q == 64'd1);

  // Next phase and parser state.
  always_comb begin
    phase_d    = phase_q;
    tag_acc_d  = tag_acc_q;
    tag_cnt_d  = tag_cnt_q;
    len_acc_d  = len_acc_q;
    len_left_d = len_left_q;
    val_left_d = val_left_q;
    if (s1_fire) begin
      case (phase_q)
        PH_TAG_FIRST, PH_TAG_MORE: begin
          tag_acc_d = tag_acc_nx;
          tag_cnt_d = tag_cnt_nx;
          if (!tag_fin) begin
            phase_d = PH_TAG_MORE;
          end else if (tag_bad) begin
            phase_d = PH_TAG_FIRST;
          end else begin
            phase_d = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST, PH_LEN_MORE: begin
          if (len_err) begin
            phase_d = PH_TAG_FIRST;
          end else begin
            len_acc_d = len_nx;
            if (phase_q == PH_LEN_FIRST) begin
              len_left_d = b[7] ? LenCntW'(b[6:0]) : '0;
            end else begin
              len_left_d = len_left_q - LenCntW'(1);
            end
            if (!hdr_fire) begin
              phase_d = PH_LEN_MORE;
            end else if (len_nx == 64'd0) begin
              phase_d = PH_TAG_FIRST;
            end else begin
              phase_d    = PH_VALUE;
              val_left_d = len_nx;
            end
          end
        end
        PH_VALUE: begin
          val_left_d = val_left_q - 64'd1;
          if (val_last) begin
            phase_d = PH_TAG_FIRST;
          end
        end
        default: phase_d = PH_TAG_FIRST;
      endcase
    end
  end

  // Result of the byte being decoded.
  always_comb begin
    res_valid_d = 1'b0;
    res_kind_d  = KIND_HEADER;
    res_last_d  = 1'b0;
    res_err_d   = ERR_TAG_MISMATCH;
    case (phase_q)
      PH_TAG_FIRST, PH_TAG_MORE: begin
        if (tag_fin && tag_bad) begin
          res_valid_d = 1'b1;
          res_kind_d  = KIND_ERROR;
        end
      end
      PH_LEN_FIRST, PH_LEN_MORE: begin
        if (len_err) begin
          res_valid_d = 1'b1;
          res_kind_d  = KIND_ERROR;
          res_err_d   = ERR_LEN_BYTES;
        end else if (hdr_fire) begin
          res_valid_d = 1'b1;
          res_last_d  = (len_nx == 64'd0);
        end
      end
      PH_VALUE: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_VALUE;
        res_last_d  = val_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG_FIRST;
      tag_acc_q   <= '0;
      tag_cnt_q   <= '0;
      len_acc_q   <= '0;
      len_left_q  <= '0;
      val_left_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      tag_acc_q  <= tag_acc_d;
      tag_cnt_q  <= tag_cnt_d;
      len_acc_q  <= len_acc_d;
      len_left_q <= len_left_d;
      val_left_q <= val_left_d;
      if (s1_fire) begin
        out_valid_o <= res_valid_d;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Fields that do not apply to a result kind are driven to zero.
  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid_d) begin
      kind_o           <= res_kind_d;
      last_o           <= res_last_d;
      error_code_o     <= (res_kind_d == KIND_ERROR) ? res_err_d : ERR_TAG_MISMATCH;
      tag_value_o      <= (res_kind_d == KIND_HEADER) ? tag_acc_q : 32'd0;
      tag_bytes_o      <= (res_kind_d == KIND_HEADER) ? 3'(tag_cnt_q) : 3'd0;
      element_length_o <= (res_kind_d == KIND_HEADER) ? len_nx : 64'd0;
      value_byte_o     <= (res_kind_d == KIND_VALUE) ? b : 8'd0;
    end
  end

  a_value_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VALUE) |-> (val_left_q != 64'd0))
    else $error("Value phase entered with no value bytes left.");

  a_len_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN_MORE) |->
      (len_left_q != '0) && (len_left_q <= LenCntW'(MaxLenBytes)))
    else $error("Length byte count out of range.");

  a_error_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_ERROR)) |-> !last_o)
    else $error("Error result marked as last.");

  a_stall_holds_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_data_q) && $stable(phase_q)))
    else $error("Buffered byte or phase changed while the result register was stalled.");

endmodule
